// ===== design/ffca_pkg.sv =====
`timescale 1ns / 1ps
package ffca_pkg;

  localparam int AW = 48;
  localparam int LW = 41;
  localparam int NW = LW + 1;
  localparam int EW = AW + LW;
  localparam int ALIGN_LG = 6;

  localparam int DEF_MAX_FREE_CHUNKS = 64;
  localparam int DEF_MAX_LIVE_BLOCKS = 256;

  localparam logic [AW-1:0] RST_POOL_BASE = '0;
  localparam logic [LW-1:0] RST_POOL_LEN  = LW'(2097152);

  localparam int CFG_IW = 2;
  typedef enum logic [CFG_IW-1:0] {
    REG_POOL_BASE = 2'd0,
    REG_POOL_LEN  = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_BADREQ = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

endpackage

// ===== design/first_fit_chunk_allocator.sv =====
`timescale 1ns / 1ps
// allocate scans the free chunks in order, plus a removal shift when a chunk is used up whole
// free does a live table scan, a free list scan and at most one list shift
// scans and shifts go one entry at a time, set by the single read port of each ram
// one request at a time; a finished result waits in the output register
// rst_n synchronous: empty live table, free list holds (pool_base, pool_len) once the init state has written it
module first_fit_chunk_allocator #(
  parameter int MAX_FREE_CHUNKS = ffca_pkg::DEF_MAX_FREE_CHUNKS,
  parameter int MAX_LIVE_BLOCKS = ffca_pkg::DEF_MAX_LIVE_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [ffca_pkg::LW-1:0]       in_req_size,
  input  logic [ffca_pkg::AW-1:0]       in_req_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [ffca_pkg::AW-1:0]       out_block_addr,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffca_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ffca_pkg::AW-1:0]       cfg_data
);

  localparam int AW  = ffca_pkg::AW;
  localparam int LW  = ffca_pkg::LW;
  localparam int NW  = ffca_pkg::NW;
  localparam int EW  = ffca_pkg::EW;
  localparam int FIW = $clog2(MAX_FREE_CHUNKS);
  localparam int FCW = $clog2(MAX_FREE_CHUNKS + 1);
  localparam int LIW = $clog2(MAX_LIVE_BLOCKS);
  localparam int LCW = $clog2(MAX_LIVE_BLOCKS + 1);
  localparam logic [NW-1:0]  AMASK = NW'((1 << ffca_pkg::ALIGN_LG) - 1);
  localparam logic [FCW-1:0] FMAX  = FCW'(MAX_FREE_CHUNKS);
  localparam logic [LCW-1:0] LMAX  = LCW'(MAX_LIVE_BLOCKS);

  typedef enum logic [13:0] {
    S_INIT     = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_AL_SCAN  = 14'b00000000000100,
    S_AL_CARVE = 14'b00000000001000,
    S_AL_ADDR  = 14'b00000000010000,
    S_LIVE_ADD = 14'b00000000100000,
    S_SHDN     = 14'b00000001000000,
    S_SHUP     = 14'b00000010000000,
    S_FR_LSCAN = 14'b00000100000000,
    S_FR_FSCAN = 14'b00001000000000,
    S_FR_EVAL  = 14'b00010000000000,
    S_FR_LMOVE = 14'b00100000000000,
    S_FR_LWR   = 14'b01000000000000,
    S_PUT      = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]  pool_base_r, pool_base_nxt;
  logic [LW-1:0]  pool_len_r, pool_len_nxt;
  logic [FCW-1:0] fcnt_r, fcnt_nxt;
  logic [LCW-1:0] lcnt_r, lcnt_nxt;
  logic [FCW-1:0] fi_r, fi_nxt, f_pi_r, f_pi_nxt, pos_r, pos_nxt;
  logic           f_pv_r, f_pv_nxt;
  logic [LCW-1:0] li_r, li_nxt, l_pi_r, l_pi_nxt;
  logic           l_pv_r, l_pv_nxt;
  logic [LIW-1:0] lhit_r, lhit_nxt;
  logic           op_r, op_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic [NW-1:0]  need_r, need_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic [AW-1:0]  fs_r, fs_nxt, prev_s_r, prev_s_nxt;
  logic [LW-1:0]  fl_r, fl_nxt, prev_l_r, prev_l_nxt, rem_r, rem_nxt, sum_r, sum_nxt;
  logic           has_cur_r, has_cur_nxt, mlo_r, mlo_nxt, mhi_r, mhi_nxt;
  logic [1:0]     st_r, st_nxt;
  logic [AW-1:0]  res_addr_r, res_addr_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [AW-1:0]  out_addr_r, out_addr_nxt;

  logic           f_we, l_we;
  logic [FIW-1:0] f_waddr, f_raddr;
  logic [LIW-1:0] l_waddr, l_raddr;
  logic [EW-1:0]  f_wdata, f_rdata, l_wdata, l_rdata;
  logic [AW-1:0]  rs, ls;
  logic [LW-1:0]  rl, ll;
  logic [NW-1:0]  req_need;
  logic [AW-1:0]  new_base;
  logic [LW-1:0]  new_size;
  logic           cfg_hit;

  ffca_ram #(.WIDTH(EW), .DEPTH(MAX_FREE_CHUNKS)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  ffca_ram #(.WIDTH(EW), .DEPTH(MAX_LIVE_BLOCKS)) u_live_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  assign rs = f_rdata[EW-1:LW];
  assign rl = f_rdata[LW-1:0];
  assign ls = l_rdata[EW-1:LW];
  assign ll = l_rdata[LW-1:0];

  assign in_ready       = (state_r == S_IDLE);
  assign cfg_ready      = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_block_addr = out_addr_r;

  // round up to the alignment
  assign req_need = ({1'b0, in_req_size} + AMASK) & ~AMASK;

  assign cfg_hit  = cfg_valid && cfg_ready &&
                    (cfg_index == ffca_pkg::REG_POOL_BASE ||
                     cfg_index == ffca_pkg::REG_POOL_LEN);
  assign new_base = (cfg_index == ffca_pkg::REG_POOL_BASE) ? cfg_data : pool_base_r;
  assign new_size = (cfg_index == ffca_pkg::REG_POOL_LEN) ? cfg_data[LW-1:0] : pool_len_r;

  always_comb begin
    state_nxt      = state_r;
    pool_base_nxt  = pool_base_r;
    pool_len_nxt   = pool_len_r;
    fcnt_nxt       = fcnt_r;
    lcnt_nxt       = lcnt_r;
    fi_nxt         = fi_r;
    f_pi_nxt       = f_pi_r;
    f_pv_nxt       = 1'b0;
    pos_nxt        = pos_r;
    li_nxt         = li_r;
    l_pi_nxt       = l_pi_r;
    l_pv_nxt       = 1'b0;
    lhit_nxt       = lhit_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    need_nxt       = need_r;
    len_nxt        = len_r;
    fs_nxt         = fs_r;
    fl_nxt         = fl_r;
    prev_s_nxt     = prev_s_r;
    prev_l_nxt     = prev_l_r;
    rem_nxt        = rem_r;
    sum_nxt        = sum_r;
    has_cur_nxt    = has_cur_r;
    mlo_nxt        = mlo_r;
    mhi_nxt        = mhi_r;
    st_nxt         = st_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    f_we           = 1'b0;
    f_waddr        = '0;
    f_wdata        = '0;
    f_raddr        = fi_r[FIW-1:0];
    l_we           = 1'b0;
    l_waddr        = '0;
    l_wdata        = '0;
    l_raddr        = li_r[LIW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        f_we      = 1'b1;
        f_wdata   = {pool_base_r, pool_len_r};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_hit) begin
          pool_base_nxt = new_base;
          pool_len_nxt  = new_size;
          f_we          = 1'b1;
          f_wdata       = {new_base, new_size};
          fcnt_nxt      = (new_size != '0) ? FCW'(1) : '0;
          lcnt_nxt      = '0;
        end
        if (in_valid) begin
          op_nxt       = in_req_type;
          addr_nxt     = in_req_addr;
          need_nxt     = req_need;
          res_addr_nxt = '0;
          fi_nxt       = '0;
          li_nxt       = '0;
          if (in_req_type == ffca_pkg::REQ_FREE) begin
            state_nxt = S_FR_LSCAN;
          end else if (in_req_size == '0) begin
            st_nxt    = ffca_pkg::ST_BADREQ;
            state_nxt = S_PUT;
          end else if (lcnt_r == LMAX) begin
            st_nxt    = ffca_pkg::ST_FULL;
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_AL_SCAN;
          end
        end
      end
      S_AL_SCAN: begin
        if (f_pv_r && ({1'b0, rl} >= need_r)) begin
          fs_nxt    = rs;
          fl_nxt    = rl;
          pos_nxt   = f_pi_r;
          state_nxt = S_AL_CARVE;
        end else if (fi_r < fcnt_r) begin
          f_pv_nxt = 1'b1;
          f_pi_nxt = fi_r;
          fi_nxt   = fi_r + FCW'(1);
        end else if (!f_pv_r) begin
          st_nxt    = ffca_pkg::ST_NOFIT;
          state_nxt = S_PUT;
        end
      end
      S_AL_CARVE: begin
        if ({1'b0, fl_r} > need_r) begin
          rem_nxt   = fl_r - need_r[LW-1:0];
          f_we      = 1'b1;
          f_waddr   = pos_r[FIW-1:0];
          f_wdata   = {fs_r, fl_r - need_r[LW-1:0]};
          state_nxt = S_AL_ADDR;
        end else begin
          res_addr_nxt = fs_r;
          fi_nxt       = pos_r + FCW'(1);
          state_nxt    = S_SHDN;
        end
      end
      S_AL_ADDR: begin
        // block sits at the high end of the chunk
        res_addr_nxt = fs_r + {{(AW-LW){1'b0}}, rem_r};
        state_nxt    = S_LIVE_ADD;
      end
      S_LIVE_ADD: begin
        l_we      = 1'b1;
        l_waddr   = lcnt_r[LIW-1:0];
        l_wdata   = {res_addr_r, need_r[LW-1:0]};
        lcnt_nxt  = lcnt_r + LCW'(1);
        st_nxt    = ffca_pkg::ST_OK;
        state_nxt = S_PUT;
      end
      S_SHDN: begin
        // copy entry k+1 down to k, one read and one write a cycle
        if (f_pv_r) begin
          f_we    = 1'b1;
          f_waddr = FIW'(f_pi_r - FCW'(1));
          f_wdata = f_rdata;
        end
        if (fi_r < fcnt_r) begin
          f_pv_nxt = 1'b1;
          f_pi_nxt = fi_r;
          fi_nxt   = fi_r + FCW'(1);
        end else if (!f_pv_r) begin
          fcnt_nxt = fcnt_r - FCW'(1);
          if (op_r == ffca_pkg::REQ_ALLOC) begin
            state_nxt = S_LIVE_ADD;
          end else begin
            st_nxt    = ffca_pkg::ST_OK;
            state_nxt = S_PUT;
          end
        end
      end
      S_SHUP: begin
        // copy entry k-1 up to k, from the top down to the insert point
        f_raddr = FIW'(fi_r - FCW'(1));
        if (f_pv_r) begin
          f_we    = 1'b1;
          f_waddr = FIW'(f_pi_r + FCW'(1));
          f_wdata = f_rdata;
        end
        if (fi_r > pos_r) begin
          f_pv_nxt = 1'b1;
          f_pi_nxt = fi_r - FCW'(1);
          fi_nxt   = fi_r - FCW'(1);
        end else if (!f_pv_r) begin
          f_we      = 1'b1;
          f_waddr   = pos_r[FIW-1:0];
          f_wdata   = {addr_r, len_r};
          fcnt_nxt  = fcnt_r + FCW'(1);
          st_nxt    = ffca_pkg::ST_OK;
          state_nxt = S_PUT;
        end
      end
      S_FR_LSCAN: begin
        if (l_pv_r && (ls == addr_r)) begin
          lhit_nxt  = l_pi_r[LIW-1:0];
          len_nxt   = ll;
          fi_nxt    = '0;
          state_nxt = S_FR_FSCAN;
        end else if (li_r < lcnt_r) begin
          l_pv_nxt = 1'b1;
          l_pi_nxt = li_r;
          li_nxt   = li_r + LCW'(1);
        end else if (!l_pv_r) begin
          st_nxt    = ffca_pkg::ST_BADREQ;
          state_nxt = S_PUT;
        end
      end
      S_FR_FSCAN: begin
        // find the first chunk above the freed address, keep the one before it
        if (f_pv_r && (rs > addr_r)) begin
          fs_nxt      = rs;
          fl_nxt      = rl;
          pos_nxt     = f_pi_r;
          has_cur_nxt = 1'b1;
          state_nxt   = S_FR_EVAL;
        end else begin
          if (f_pv_r) begin
            prev_s_nxt = rs;
            prev_l_nxt = rl;
          end
          if (fi_r < fcnt_r) begin
            f_pv_nxt = 1'b1;
            f_pi_nxt = fi_r;
            fi_nxt   = fi_r + FCW'(1);
          end else if (!f_pv_r) begin
            pos_nxt     = fcnt_r;
            has_cur_nxt = 1'b0;
            state_nxt   = S_FR_EVAL;
          end
        end
      end
      S_FR_EVAL: begin
        mlo_nxt = (pos_r != '0) &&
                  ((prev_s_r + {{(AW-LW){1'b0}}, prev_l_r}) == addr_r);
        mhi_nxt = has_cur_r && ((addr_r + {{(AW-LW){1'b0}}, len_r}) == fs_r);
        sum_nxt = prev_l_r + len_r;
        if (!mlo_nxt && !mhi_nxt && (fcnt_r == FMAX)) begin
          st_nxt    = ffca_pkg::ST_FULL;
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_FR_LMOVE;
        end
      end
      S_FR_LMOVE: begin
        l_raddr   = LIW'(lcnt_r - LCW'(1));
        state_nxt = S_FR_LWR;
      end
      S_FR_LWR: begin
        // last live entry fills the freed slot
        l_we     = 1'b1;
        l_waddr  = lhit_r;
        l_wdata  = l_rdata;
        lcnt_nxt = lcnt_r - LCW'(1);
        if (mlo_r && mhi_r) begin
          f_we      = 1'b1;
          f_waddr   = FIW'(pos_r - FCW'(1));
          f_wdata   = {prev_s_r, sum_r + fl_r};
          fi_nxt    = pos_r + FCW'(1);
          state_nxt = S_SHDN;
        end else if (mlo_r) begin
          f_we      = 1'b1;
          f_waddr   = FIW'(pos_r - FCW'(1));
          f_wdata   = {prev_s_r, sum_r};
          st_nxt    = ffca_pkg::ST_OK;
          state_nxt = S_PUT;
        end else if (mhi_r) begin
          f_we      = 1'b1;
          f_waddr   = pos_r[FIW-1:0];
          f_wdata   = {addr_r, fl_r + len_r};
          st_nxt    = ffca_pkg::ST_OK;
          state_nxt = S_PUT;
        end else begin
          fi_nxt    = fcnt_r;
          state_nxt = S_SHUP;
        end
      end
      S_PUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_addr_nxt   = (st_r == ffca_pkg::ST_OK) ? res_addr_r : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pool_base_r <= ffca_pkg::RST_POOL_BASE;
      pool_len_r  <= ffca_pkg::RST_POOL_LEN;
      fcnt_r      <= FCW'(1);
      lcnt_r      <= '0;
      f_pv_r      <= 1'b0;
      l_pv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_base_r <= pool_base_nxt;
      pool_len_r  <= pool_len_nxt;
      fcnt_r      <= fcnt_nxt;
      lcnt_r      <= lcnt_nxt;
      f_pv_r      <= f_pv_nxt;
      l_pv_r      <= l_pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fi_r         <= fi_nxt;
    f_pi_r       <= f_pi_nxt;
    pos_r        <= pos_nxt;
    li_r         <= li_nxt;
    l_pi_r       <= l_pi_nxt;
    lhit_r       <= lhit_nxt;
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    need_r       <= need_nxt;
    len_r        <= len_nxt;
    fs_r         <= fs_nxt;
    fl_r         <= fl_nxt;
    prev_s_r     <= prev_s_nxt;
    prev_l_r     <= prev_l_nxt;
    rem_r        <= rem_nxt;
    sum_r        <= sum_nxt;
    has_cur_r    <= has_cur_nxt;
    mlo_r        <= mlo_nxt;
    mhi_r        <= mhi_nxt;
    st_r         <= st_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= FMAX)
    else $error("free count above capacity");

  a_lcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    lcnt_r <= LMAX)
    else $error("live count above capacity");

  a_shup_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHUP |-> fcnt_r < FMAX)
    else $error("insert shift with full free list");

  a_shdn_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHDN && f_pv_r) |-> f_pi_r != '0)
    else $error("removal shift writes below entry zero");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT && (!out_valid_r || out_ready) && st_r != ffca_pkg::ST_OK)
      |=> out_block_addr == '0)
    else $error("failed request returned nonzero address");

endmodule

// ===== design/ffca_ram.sv =====
`timescale 1ns / 1ps
module ffca_ram #(
  parameter int WIDTH = 89,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
